FILE: sv/positional_array_list_top_defines.svh
// Assertion macros for the positional array list RTL.
`ifndef POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pal_pkg.sv
// Shared types, constants and helpers for the positional array list.
`default_nettype none

package pal_pkg;

    localparam int DEPTH  = 128;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CW > 9) ? CW : 9;
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 8;
    localparam int TDATA_W = 48;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } stat_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_DRAIN = 5'b00100,
        S_PLACE = 5'b01000,
        S_READ  = 5'b10000
    } state_t;

    // Low eight bits of the entry count.
    function automatic logic [LEN_W-1:0] len8(input logic [CW-1:0] cnt);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(cnt);
        return ext[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/positional_array_list_top.sv
// Top level of the positional array list: request decode, shift sequencer, entry RAM.
// A read passes the registered RAM read and the S_READ state; write, append, tail delete
// and rejected requests load the result word on acceptance. Insert inside the list runs
// S_SHIFT, S_DRAIN and S_PLACE, delete inside it S_SHIFT and S_DRAIN. One request is taken
// at a time; the shifts are bound by the single RAM port pair that moves one entry per cycle.
// Reset: asynchronous, active low; clears the entry count, sequencer and output valid.
// Entry storage is not cleared; only positions 1..length are ever read.
`default_nettype none

module positional_array_list_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] op, [9:2] position, [41:10] value, [47:42] zero
    input  wire logic [pal_pkg::TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status, [33:2] read_value, [41:34] list_length, [47:42] zero
    output logic      [pal_pkg::TDATA_W-1:0]   m_tdata
);

`include "positional_array_list_top_defines.svh"

    // Unpack the request word.
    pal_pkg::op_t                         in_op;
    logic [pal_pkg::POS_W-1:0]            in_pos;
    logic signed [pal_pkg::DATA_W-1:0]    in_val;
    logic                                 in_acc;

    assign in_op  = pal_pkg::op_t'(s_tdata[1:0]);
    assign in_pos = s_tdata[9:2];
    assign in_val = s_tdata[41:10];

    // Sequencer and list state.
    pal_pkg::state_t                      state_reg, state_next;
    logic [pal_pkg::CW-1:0]               count_reg, count_next;
    logic [pal_pkg::AW-1:0]               rd_idx_reg, rd_idx_next;
    logic [pal_pkg::AW-1:0]               prev_idx_reg, prev_idx_next;
    logic [pal_pkg::AW-1:0]               end_idx_reg, end_idx_next;
    logic                                 up_reg, up_next;
    logic                                 pend_reg, pend_next;
    logic signed [pal_pkg::DATA_W-1:0]    val_reg, val_next;

    // Output word register.
    logic                                 out_valid_reg, out_valid_next;
    pal_pkg::stat_t                       out_status_reg, out_status_next;
    logic signed [pal_pkg::DATA_W-1:0]    out_rd_reg, out_rd_next;
    logic [pal_pkg::LEN_W-1:0]            out_len_reg, out_len_next;
    logic                                 out_load;
    logic                                 out_free;

    // RAM port signals.
    logic                                 ram_we;
    logic [pal_pkg::AW-1:0]               ram_waddr;
    logic [pal_pkg::DATA_W-1:0]           ram_wdata;
    logic                                 ram_re;
    logic [pal_pkg::AW-1:0]               ram_raddr;
    logic [pal_pkg::DATA_W-1:0]           ram_rdata;

    // Request check against the current length.
    logic [pal_pkg::CMP_W-1:0]            pos_ext, cnt_ext, pos_m1, cnt_m1;
    pal_pkg::stat_t                       dec_status;
    logic [pal_pkg::AW-1:0]               shift_waddr;

    assign pos_ext = pal_pkg::CMP_W'(in_pos);
    assign cnt_ext = pal_pkg::CMP_W'(count_reg);
    assign pos_m1  = pos_ext - pal_pkg::CMP_W'(1);
    assign cnt_m1  = cnt_ext - pal_pkg::CMP_W'(1);

    always_comb
    begin
        dec_status = pal_pkg::STAT_OK;
        if (in_op == pal_pkg::OP_INSERT)
        begin
            // Full test comes before the position test.
            if (count_reg == pal_pkg::CW'(pal_pkg::DEPTH))
            begin
                dec_status = pal_pkg::STAT_FULL;
            end
            else if (pos_ext == '0 || pos_ext > cnt_ext + pal_pkg::CMP_W'(1))
            begin
                dec_status = pal_pkg::STAT_BADPOS;
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                dec_status = pal_pkg::STAT_EMPTY;
            end
            else if (pos_ext == '0 || pos_ext > cnt_ext)
            begin
                dec_status = pal_pkg::STAT_BADPOS;
            end
        end
    end

    // Accept only in idle, and only when the output word is free or leaving now.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == pal_pkg::S_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // Destination of a moved entry: one above its source on insert, one below on delete.
    assign shift_waddr = up_reg ? (prev_idx_reg + pal_pkg::AW'(1))
                                : (prev_idx_reg - pal_pkg::AW'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        prev_idx_next   = prev_idx_reg;
        end_idx_next    = end_idx_reg;
        up_next         = up_reg;
        pend_next       = pend_reg;
        val_next        = val_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_rd_next     = out_rd_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            pal_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (dec_status != pal_pkg::STAT_OK)
                    begin
                        // Reject: report at once, leave the list alone.
                        out_load        = 1'b1;
                        out_status_next = dec_status;
                        out_rd_next     = '0;
                    end
                    else
                    begin
                        case (in_op)
                            pal_pkg::OP_INSERT:
                            begin
                                if (pos_ext == cnt_ext + pal_pkg::CMP_W'(1))
                                begin
                                    // Append: nothing to move.
                                    ram_we          = 1'b1;
                                    ram_waddr       = cnt_ext[pal_pkg::AW-1:0];
                                    ram_wdata       = in_val;
                                    count_next      = count_reg + pal_pkg::CW'(1);
                                    out_load        = 1'b1;
                                    out_status_next = pal_pkg::STAT_OK;
                                    out_rd_next     = '0;
                                end
                                else
                                begin
                                    // Move the tail up, walking down from the last entry.
                                    val_next     = in_val;
                                    up_next      = 1'b1;
                                    pend_next    = 1'b0;
                                    rd_idx_next  = cnt_m1[pal_pkg::AW-1:0];
                                    end_idx_next = pos_m1[pal_pkg::AW-1:0];
                                    state_next   = pal_pkg::S_SHIFT;
                                end
                            end
                            pal_pkg::OP_DELETE:
                            begin
                                if (pos_ext == cnt_ext)
                                begin
                                    // Drop the last entry: nothing to move.
                                    count_next      = count_reg - pal_pkg::CW'(1);
                                    out_load        = 1'b1;
                                    out_status_next = pal_pkg::STAT_OK;
                                    out_rd_next     = '0;
                                end
                                else
                                begin
                                    // Move the tail down, walking up from the next entry.
                                    up_next      = 1'b0;
                                    pend_next    = 1'b0;
                                    rd_idx_next  = pos_ext[pal_pkg::AW-1:0];
                                    end_idx_next = cnt_m1[pal_pkg::AW-1:0];
                                    state_next   = pal_pkg::S_SHIFT;
                                end
                            end
                            pal_pkg::OP_READ:
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = pos_m1[pal_pkg::AW-1:0];
                                state_next = pal_pkg::S_READ;
                            end
                            pal_pkg::OP_WRITE:
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = pos_m1[pal_pkg::AW-1:0];
                                ram_wdata       = in_val;
                                out_load        = 1'b1;
                                out_status_next = pal_pkg::STAT_OK;
                                out_rd_next     = '0;
                            end
                            default:
                            begin
                                state_next = pal_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end
            pal_pkg::S_SHIFT:
            begin
                // Read one entry and write back the one read last cycle.
                ram_re    = 1'b1;
                ram_raddr = rd_idx_reg;
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_waddr;
                    ram_wdata = ram_rdata;
                end
                prev_idx_next = rd_idx_reg;
                pend_next     = 1'b1;
                if (rd_idx_reg == end_idx_reg)
                begin
                    state_next = pal_pkg::S_DRAIN;
                end
                else
                begin
                    rd_idx_next = up_reg ? (rd_idx_reg - pal_pkg::AW'(1))
                                         : (rd_idx_reg + pal_pkg::AW'(1));
                end
            end
            pal_pkg::S_DRAIN:
            begin
                // Write the last moved entry.
                ram_we    = 1'b1;
                ram_waddr = shift_waddr;
                ram_wdata = ram_rdata;
                pend_next = 1'b0;
                if (up_reg)
                begin
                    state_next = pal_pkg::S_PLACE;
                end
                else
                begin
                    count_next      = count_reg - pal_pkg::CW'(1);
                    out_load        = 1'b1;
                    out_status_next = pal_pkg::STAT_OK;
                    out_rd_next     = '0;
                    state_next      = pal_pkg::S_IDLE;
                end
            end
            pal_pkg::S_PLACE:
            begin
                // Put the new value into the opened slot.
                ram_we          = 1'b1;
                ram_waddr       = end_idx_reg;
                ram_wdata       = val_reg;
                count_next      = count_reg + pal_pkg::CW'(1);
                out_load        = 1'b1;
                out_status_next = pal_pkg::STAT_OK;
                out_rd_next     = '0;
                state_next      = pal_pkg::S_IDLE;
            end
            pal_pkg::S_READ:
            begin
                out_load        = 1'b1;
                out_status_next = pal_pkg::STAT_OK;
                out_rd_next     = ram_rdata;
                state_next      = pal_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pal_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result word until it is taken.
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);
    assign out_len_next   = out_load ? pal_pkg::len8(count_next) : out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pal_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        prev_idx_reg   <= prev_idx_next;
        end_idx_reg    <= end_idx_next;
        up_reg         <= up_next;
        val_reg        <= val_next;
        out_status_reg <= out_status_next;
        out_rd_reg     <= out_rd_next;
        out_len_reg    <= out_len_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_len_reg, out_rd_reg, out_status_reg};

    // Entry store.
    pal_ram #(
        .WIDTH (pal_pkg::DATA_W),
        .DEPTH (pal_pkg::DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `PAL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= pal_pkg::CW'(pal_pkg::DEPTH), "entry count above depth")
    `PAL_ASSERT_NOW(a_full_only_at_depth, clk, rst_n,
        out_load && out_status_next == pal_pkg::STAT_FULL,
        count_reg == pal_pkg::CW'(pal_pkg::DEPTH), "full reported below depth")
    `PAL_ASSERT_NOW(a_no_idle_write, clk, rst_n,
        state_reg == pal_pkg::S_IDLE && !in_acc, !ram_we, "RAM write while idle")
    `PAL_ASSERT_NEXT(a_delete_shrinks, clk, rst_n,
        state_reg == pal_pkg::S_DRAIN && !up_reg,
        out_valid_reg && count_reg == $past(count_reg) - pal_pkg::CW'(1),
        "delete did not shrink the list")

endmodule

`default_nettype wire

FILE: sv/pal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
